// ----- rtl/ghp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generational handle pool package
// Shared constants, result codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package ghp_pkg;

  localparam int unsigned DEF_MAX_SLOTS        = 1023;
  localparam int unsigned DEF_INDEX_FIELD_BITS = 16;

  localparam int unsigned SLOT_W   = 10;
  localparam int unsigned GEN_W    = 16;
  localparam int unsigned ID_W     = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;

  // Reset value of the pool size register before clamping.
  localparam logic [SLOT_W-1:0] POOL_SLOTS_RST = 10'd1023;

  // Opcode values of an input item.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Register word index of the pool size register.
  localparam logic REG_POOL_SLOTS = 1'b0;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_BAD_FREE  = 2'd2
  } ghp_status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic        latch;     // capture the input item
    logic        pop;       // read top of stack and decrement
    logic        push;      // write slot index at top and increment
    logic        gen_rd;    // resolve popped slot and read its generation
    logic        gen_wr;    // write incremented generation, alloc result
    logic        emit;      // load the result registers
    ghp_status_e emit_status;
  } ghp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_free;
    logic empty;
    logic bad_free;
    logic clearing;
  } ghp_sts_t;

endpackage

// ----- rtl/ghp_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generational handle pool controller
// Decodes one item at a time; allocs go on to stack pop and generation update.
// ----------------------------------------------------------------------------
module ghp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  ghp_pkg::ghp_sts_t sts_i,
  output ghp_pkg::ghp_cmd_t cmd_o,
  output logic              busy_o
);
  import ghp_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_STACK,
    S_GEN
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;

  always_comb begin
    cmd_o             = '0;
    cmd_o.emit_status = ST_OK;
    state_d           = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i && !sts_i.clearing) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!sts_i.is_free) begin
          if (sts_i.empty) begin
            cmd_o.emit        = 1'b1;
            cmd_o.emit_status = ST_EXHAUSTED;
            state_d           = S_IDLE;
          end else begin
            cmd_o.pop = 1'b1;
            state_d   = S_STACK;
          end
        end else begin
          cmd_o.emit = 1'b1;
          if (sts_i.bad_free) begin
            cmd_o.emit_status = ST_BAD_FREE;
          end else begin
            cmd_o.push = 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      S_STACK: begin
        cmd_o.gen_rd = 1'b1;
        state_d      = S_GEN;
      end
      S_GEN: begin
        cmd_o.gen_wr = 1'b1;
        cmd_o.emit   = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != S_IDLE);
    end
  end

  assign busy_o = busy_q || sts_i.clearing;

endmodule

// ----- rtl/ghp_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generational handle pool datapath
// Free stack memory, generation memory with clearing pass, config register.
// ----------------------------------------------------------------------------
module ghp_datapath #(
  parameter int unsigned MAX_SLOTS        = ghp_pkg::DEF_MAX_SLOTS,
  parameter int unsigned INDEX_FIELD_BITS = ghp_pkg::DEF_INDEX_FIELD_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ghp_pkg::ghp_cmd_t             cmd_i,
  output ghp_pkg::ghp_sts_t             sts_o,
  input  logic                          opcode_i,
  input  logic [ghp_pkg::SLOT_W-1:0]    slot_index_i,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ghp_pkg::APB_AW-1:0]    paddr,
  input  logic [ghp_pkg::APB_DW-1:0]    pwdata,
  output logic [ghp_pkg::APB_DW-1:0]    prdata,
  output logic                          done_o,
  output logic [ghp_pkg::STATUS_W-1:0]  status_o,
  output logic [ghp_pkg::SLOT_W-1:0]    granted_index_o,
  output logic [ghp_pkg::ID_W-1:0]      resource_id_o
);
  import ghp_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_SLOTS + 1);
  localparam int unsigned SAW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned GW  = $clog2(MAX_SLOTS + 1);
  localparam int unsigned XW  = 17;
  localparam logic [XW-1:0] MAX_X = XW'(MAX_SLOTS);
  localparam logic [SLOT_W-1:0] N_RST =
    (MAX_SLOTS < 1023) ? SLOT_W'(MAX_SLOTS) : POOL_SLOTS_RST;
  localparam logic [63:0] IDX_MASK = (64'd1 << INDEX_FIELD_BITS) - 64'd1;

  logic [SLOT_W-1:0] smem [MAX_SLOTS];
  logic [GEN_W-1:0]  gmem [MAX_SLOTS+1];

  logic              op_q;
  logic [SLOT_W-1:0] idx_q;
  logic [SLOT_W-1:0] n_q;
  logic [CW-1:0]     top_q;
  logic [CW-1:0]     low_q;
  logic              clr_busy_q;
  logic [GW-1:0]     clr_cnt_q;
  logic              orig_q;
  logic [SLOT_W-1:0] orig_val_q;
  logic [SLOT_W-1:0] srd_q;
  logic [SLOT_W-1:0] s_q;
  logic [GEN_W-1:0]  grd_q;
  logic              done_q;
  logic [STATUS_W-1:0] status_q;
  logic [SLOT_W-1:0] granted_q;
  logic [ID_W-1:0]   id_q;

  logic              cfg_wr;
  logic [SLOT_W-1:0] n_new;
  logic [CW-1:0]     pop_pos;
  logic [XW-1:0]     orig_calc;
  logic [SLOT_W-1:0] s_raw;
  logic [SLOT_W-1:0] s_res;
  logic [GEN_W-1:0]  g_next;
  logic [63:0]       id_wide;

  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_POOL_SLOTS);

  // Pool size clamped to the range one to the maximum slot count.
  always_comb begin
    n_new = pwdata[SLOT_W-1:0];
    if (n_new == '0) begin
      n_new = SLOT_W'(1);
    end else if ({7'd0, n_new} > MAX_X) begin
      n_new = SLOT_W'(MAX_SLOTS);
    end
  end

  assign prdata = (paddr[2] == REG_POOL_SLOTS) ? {{(APB_DW-SLOT_W){1'b0}}, n_q} : '0;

  assign pop_pos   = top_q - CW'(1);
  assign orig_calc = {7'd0, n_q} - XW'(pop_pos);

  // Entries below the low-water mark were never pushed since the last reload.
  assign s_raw = orig_q ? orig_val_q : srd_q;
  assign s_res = ({7'd0, s_raw} > MAX_X) ? '0 : s_raw;

  assign g_next  = grd_q + GEN_W'(1);
  assign id_wide = ({48'd0, g_next} << INDEX_FIELD_BITS) | ({54'd0, s_q} & IDX_MASK);

  assign sts_o.is_free  = (op_q == OP_FREE);
  assign sts_o.empty    = (top_q == '0);
  assign sts_o.bad_free = (idx_q == '0) || ({7'd0, idx_q} > {7'd0, n_q})
                       || (XW'(top_q) >= {7'd0, n_q}) || (XW'(top_q) >= MAX_X);
  assign sts_o.clearing = clr_busy_q;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q        <= N_RST;
      top_q      <= CW'(N_RST);
      low_q      <= CW'(N_RST);
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
      done_q     <= 1'b0;
    end else begin
      done_q <= cmd_i.emit;
      if (cfg_wr) begin
        n_q        <= n_new;
        top_q      <= CW'(n_new);
        low_q      <= CW'(n_new);
        clr_busy_q <= 1'b1;
        clr_cnt_q  <= '0;
      end else begin
        if (clr_busy_q) begin
          if (clr_cnt_q == GW'(MAX_SLOTS)) begin
            clr_busy_q <= 1'b0;
          end
          clr_cnt_q <= clr_cnt_q + GW'(1);
        end
        if (cmd_i.pop) begin
          top_q <= pop_pos;
          if (pop_pos < low_q) begin
            low_q <= pop_pos;
          end
        end else if (cmd_i.push) begin
          top_q <= top_q + CW'(1);
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q  <= opcode_i;
      idx_q <= slot_index_i;
    end
    if (cmd_i.pop) begin
      orig_q     <= (pop_pos < low_q);
      orig_val_q <= orig_calc[SLOT_W-1:0];
    end
    if (cmd_i.gen_rd) begin
      s_q <= s_res;
    end
    if (cmd_i.emit) begin
      status_q <= cmd_i.emit_status;
      if (cmd_i.gen_wr) begin
        granted_q <= s_q;
        id_q      <= id_wide[ID_W-1:0];
      end else begin
        granted_q <= '0;
        id_q      <= '0;
      end
    end
  end

  // Free stack memory.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      smem[top_q[SAW-1:0]] <= idx_q;
    end
    if (cmd_i.pop) begin
      srd_q <= smem[pop_pos[SAW-1:0]];
    end
  end

  // Generation memory; the clearing pass owns the write port while it runs.
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      gmem[clr_cnt_q] <= '0;
    end else if (cmd_i.gen_wr) begin
      gmem[GW'(s_q)] <= g_next;
    end
    if (cmd_i.gen_rd) begin
      grd_q <= gmem[GW'(s_res)];
    end
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign granted_index_o = granted_q;
  assign resource_id_o   = id_q;

endmodule

// ----- rtl/generational_handle_pool_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generational handle pool core
// Hands out slot indices from a free stack and tags them with per-slot
// wrapping generations to form resource ids; frees push indices back.
// ----------------------------------------------------------------------------
// An allocate passes decode, the stack memory read and the generation memory
// read-modify-write before its done_o strobe; a free or a rejected allocate
// gives its strobe from decode. busy stays high until the strobe, so a new item
// is taken only once the last one is through. Reset and every pool_slots write
// start a clearing pass over all MAX_SLOTS+1 generation memory entries; busy is
// high during it. Results cannot be stalled.
// ----------------------------------------------------------------------------
//
// The controller (ghp_ctrl) decodes each item; an allocate then takes a stack
// pop and a generation update. The datapath (ghp_datapath) owns the pool size
// register, the free stack and generation memories and the result registers.
//
// The free stack is never rewritten on reload. A low-water mark tracks the
// lowest stack depth reached since the last reload: positions below it still
// hold their reload value, which is computed as pool_slots minus the position.
//
// The APB port has one register, pool_slots, at byte address 0. Writes must
// only be issued while no item is in flight, and each one restarts the
// clearing pass; pready is always high.
module generational_handle_pool_core #(
  parameter int unsigned MAX_SLOTS        = ghp_pkg::DEF_MAX_SLOTS,
  parameter int unsigned INDEX_FIELD_BITS = ghp_pkg::DEF_INDEX_FIELD_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          opcode_i,
  input  logic [ghp_pkg::SLOT_W-1:0]    slot_index_i,
  output logic                          done_o,
  output logic [ghp_pkg::STATUS_W-1:0]  status_o,
  output logic [ghp_pkg::SLOT_W-1:0]    granted_index_o,
  output logic [ghp_pkg::ID_W-1:0]      resource_id_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ghp_pkg::APB_AW-1:0]    paddr,
  input  logic [ghp_pkg::APB_DW-1:0]    pwdata,
  output logic [ghp_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);
  import ghp_pkg::*;

  ghp_cmd_t cmd;
  ghp_sts_t sts;

  // The register port never inserts wait states.
  assign pready = 1'b1;

  ghp_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  ghp_datapath #(
    .MAX_SLOTS        (MAX_SLOTS),
    .INDEX_FIELD_BITS (INDEX_FIELD_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .opcode_i        (opcode_i),
    .slot_index_i    (slot_index_i),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .done_o          (done_o),
    .status_o        (status_o),
    .granted_index_o (granted_index_o),
    .resource_id_o   (resource_id_o)
  );

endmodule
